// ===== rtl/core/pcfm_pkg.sv =====
// Shared constants, register indexes and segment decode for the period-capture frequency meter.
`default_nettype none
package pcfm_pkg;

    // Fixed field widths
    localparam int DIVIDEND_W = 24;
    localparam int PERIOD_W   = 16;
    localparam int FREQ_W     = 14;
    localparam int PRESET_W   = 8;
    localparam int SEG_W      = 8;
    localparam int BCD_DIGITS = 4;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_PRESET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_SELECT      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [PRESET_W-1:0]   RESET_PRESET = 8'd8;
    localparam logic [DIVIDEND_W-1:0] RESET_TPS    = 24'd1000000;

    // Blank digit: all segments and decimal point off
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    // Largest shown frequency for a display of the given number of digits
    function automatic logic [FREQ_W-1:0] display_limit(input int digits);
        int lim;
        lim = 1;
        for (int i = 0; i < 4; i++) begin
            if (i < digits) begin
                lim = lim * 10;
            end
        end
        return FREQ_W'(lim - 1);
    endfunction

    // Active-low seven-segment code of one decimal digit, segment a in bit 0
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pcfm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module pcfm_div import pcfm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [PERIOD_W-1:0]   divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [PERIOD_W-1:0]   divisor_reg, divisor_next;
    logic [PERIOD_W:0]     shifted;
    logic [PERIOD_W:0]     diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        shifted      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff         = shifted - {1'b0, divisor_reg};
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start) begin
            cnt_next     = CNT_W'(DIVIDEND_W);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[PERIOD_W]) begin
                rem_next = diff[PERIOD_W-1:0];
            end else begin
                rem_next = shifted[PERIOD_W-1:0];
            end
            quo_next = {quo_reg[DIVIDEND_W-2:0], ~diff[PERIOD_W]};
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    // Hold the control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pcfm_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`default_nettype none
module pcfm_bcd import pcfm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [FREQ_W-1:0] bin,
    output logic                   done,
    output logic [BCD_W-1:0]       bcd
);

    localparam int CNT_W = $clog2(FREQ_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [FREQ_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]  adj;

    // Correct each digit that would overflow, then shift one binary bit in
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        if (start) begin
            cnt_next = CNT_W'(FREQ_W);
            bcd_next = '0;
            bin_next = bin;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            bcd_next = {adj[BCD_W-2:0], bin_reg[FREQ_W-1]};
            bin_next = {bin_reg[FREQ_W-2:0], 1'b0};
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    // Hold the control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Advance the shift registers
    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

// ===== rtl/core/period_capture_frequency_meter.sv =====
// Top level of the period-capture frequency meter.
`default_nettype none
// Each input transaction is one timer tick with the sampled input level. A tick
// without the selected edge gives no result; the block is ready again on the
// next cycle. A tick with the edge captures the period, reloads the counter and
// starts the result: a bit-serial divider computes ticks_per_second / period,
// then a bit-serial BCD converter forms the digits. s_ready stays low from the
// capture until the result moves into the result register, and that move waits
// while the previous result is still waiting on m_ready. The result register
// lets the next ticks be taken while a finished result waits. Configuration
// writes are always accepted.
module period_capture_frequency_meter import pcfm_pkg::*; #(
    parameter int COUNTER_BITS   = 16,
    parameter int DISPLAY_DIGITS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIVIDEND_W-1:0] cfg_data,
    // tick channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_signal_level,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PERIOD_W-1:0]        m_period_ticks,
    output logic [FREQ_W-1:0]          m_frequency_hz,
    output logic [SEG_W-1:0]           m_seg_thousands,
    output logic [SEG_W-1:0]           m_seg_hundreds,
    output logic [SEG_W-1:0]           m_seg_tens,
    output logic [SEG_W-1:0]           m_seg_ones,
    output logic                       m_over_range,
    output logic                       m_zero_period,
    output logic                       m_counter_saturated
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [FREQ_W-1:0]       LIMIT   = display_limit(DISPLAY_DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_BCD  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // control and configuration state
    logic [1:0]              state_reg, state_next;
    logic [COUNTER_BITS-1:0] tick_cnt_reg, tick_cnt_next;
    logic                    prev_level_reg, prev_level_next;
    logic                    sat_flag_reg, sat_flag_next;
    logic [PRESET_W-1:0]     preset_reg, preset_next;
    logic [DIVIDEND_W-1:0]   tps_reg, tps_next;
    logic                    edge_sel_reg, edge_sel_next;
    logic                    m_valid_reg, m_valid_next;

    // pending result fields
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic                    sat_pend_reg, sat_pend_next;
    logic                    zero_reg, zero_next;
    logic [FREQ_W-1:0]       freq_reg, freq_next;
    logic                    over_reg, over_next;

    // result register
    logic [PERIOD_W-1:0]     out_period_reg, out_period_next;
    logic [FREQ_W-1:0]       out_freq_reg, out_freq_next;
    logic [SEG_W-1:0]        out_seg_reg [BCD_DIGITS];
    logic [SEG_W-1:0]        out_seg_next [BCD_DIGITS];
    logic                    out_over_reg, out_over_next;
    logic                    out_zero_reg, out_zero_next;
    logic                    out_sat_reg, out_sat_next;

    logic                    s_accept;
    logic                    capture;
    logic                    cnt_hi_nz;
    logic [PERIOD_W-1:0]     period_now;
    logic                    out_free;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_quotient;
    logic                    bcd_start;
    logic [FREQ_W-1:0]       freq_sat;
    logic                    over_now;
    logic                    bcd_done;
    logic [BCD_W-1:0]        bcd_digits;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign capture   = s_accept && (s_signal_level != prev_level_reg)
                       && (s_signal_level == edge_sel_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Clamp a wide counter to the 16-bit period field
    assign cnt_hi_nz  = (COUNTER_BITS > PERIOD_W) ? |(tick_cnt_reg >> PERIOD_W) : 1'b0;
    assign period_now = cnt_hi_nz ? '1 : PERIOD_W'(tick_cnt_reg);

    // Saturate the quotient at the display limit; a zero period forces zero
    always_comb begin
        freq_sat = FREQ_W'(div_quotient);
        over_now = 1'b0;
        if (zero_reg) begin
            freq_sat = '0;
        end else if (div_quotient > DIVIDEND_W'(LIMIT)) begin
            freq_sat = LIMIT;
            over_now = 1'b1;
        end
    end

    assign bcd_start = (state_reg == ST_DIV) && div_done;

    pcfm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (capture),
        .dividend (tps_reg),
        .divisor  (period_now),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pcfm_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin     (freq_sat),
        .done    (bcd_done),
        .bcd     (bcd_digits)
    );

    // Next-state logic for counter, configuration, sequencer and result slot
    always_comb begin
        state_next      = state_reg;
        tick_cnt_next   = tick_cnt_reg;
        prev_level_next = prev_level_reg;
        sat_flag_next   = sat_flag_reg;
        preset_next     = preset_reg;
        tps_next        = tps_reg;
        edge_sel_next   = edge_sel_reg;
        m_valid_next    = m_valid_reg;
        period_next     = period_reg;
        sat_pend_next   = sat_pend_reg;
        zero_next       = zero_reg;
        freq_next       = freq_reg;
        over_next       = over_reg;
        out_period_next = out_period_reg;
        out_freq_next   = out_freq_reg;
        out_seg_next    = out_seg_reg;
        out_over_next   = out_over_reg;
        out_zero_next   = out_zero_reg;
        out_sat_next    = out_sat_reg;

        // write configuration; unknown indexes drop
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RELOAD_PRESET:    preset_next   = cfg_data[PRESET_W-1:0];
                REG_TICKS_PER_SECOND: tps_next      = cfg_data;
                REG_EDGE_SELECT:      edge_sel_next = cfg_data[0];
                default:              ;
            endcase
        end

        // count ticks, saturating; capture and reload on the selected edge
        if (s_accept) begin
            prev_level_next = s_signal_level;
            if (capture) begin
                period_next   = period_now;
                sat_pend_next = sat_flag_reg;
                zero_next     = (period_now == '0);
                tick_cnt_next = COUNTER_BITS'(preset_reg);
                sat_flag_next = 1'b0;
                state_next    = ST_DIV;
            end else begin
                if (tick_cnt_reg != CNT_MAX) begin
                    tick_cnt_next = tick_cnt_reg + 1'b1;
                end
                if (tick_cnt_next == CNT_MAX) begin
                    sat_flag_next = 1'b1;
                end
            end
        end

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: ;
            ST_DIV: begin
                if (div_done) begin
                    freq_next  = freq_sat;
                    over_next  = over_now;
                    state_next = ST_BCD;
                end
            end
            ST_BCD: begin
                if (bcd_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_period_next = period_reg;
                    out_freq_next   = freq_reg;
                    out_over_next   = over_reg;
                    out_zero_next   = zero_reg;
                    out_sat_next    = sat_pend_reg;
                    for (int d = 0; d < BCD_DIGITS; d++) begin
                        if (d < DISPLAY_DIGITS) begin
                            out_seg_next[d] = seg_code(bcd_digits[4*d +: 4]);
                        end else begin
                            out_seg_next[d] = SEG_BLANK;
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold control and configuration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_cnt_reg   <= '0;
            prev_level_reg <= 1'b0;
            sat_flag_reg   <= 1'b0;
            preset_reg     <= RESET_PRESET;
            tps_reg        <= RESET_TPS;
            edge_sel_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_cnt_reg   <= tick_cnt_next;
            prev_level_reg <= prev_level_next;
            sat_flag_reg   <= sat_flag_next;
            preset_reg     <= preset_next;
            tps_reg        <= tps_next;
            edge_sel_reg   <= edge_sel_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        period_reg     <= period_next;
        sat_pend_reg   <= sat_pend_next;
        zero_reg       <= zero_next;
        freq_reg       <= freq_next;
        over_reg       <= over_next;
        out_period_reg <= out_period_next;
        out_freq_reg   <= out_freq_next;
        out_seg_reg    <= out_seg_next;
        out_over_reg   <= out_over_next;
        out_zero_reg   <= out_zero_next;
        out_sat_reg    <= out_sat_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_period_ticks      = out_period_reg;
    assign m_frequency_hz      = out_freq_reg;
    assign m_seg_ones          = out_seg_reg[0];
    assign m_seg_tens          = out_seg_reg[1];
    assign m_seg_hundreds      = out_seg_reg[2];
    assign m_seg_thousands     = out_seg_reg[3];
    assign m_over_range        = out_over_reg;
    assign m_zero_period       = out_zero_reg;
    assign m_counter_saturated = out_sat_reg;

endmodule
`default_nettype wire
